// ----- hdl/wws_pkg.sv -----
// shared constants and types for the word wrap stream block
package wws_pkg;

  localparam int CHAR_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int WRAP_W     = 6;
  localparam int MODE_W     = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_END_MODE = 2'd1;

  // line end modes
  localparam logic [MODE_W-1:0] LE_CR   = 2'd0;
  localparam logic [MODE_W-1:0] LE_CRLF = 2'd1;
  localparam logic [MODE_W-1:0] LE_LF   = 2'd2;

  // request types
  localparam logic REQ_TEXT  = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  localparam logic [WRAP_W-1:0] WRAP_RESET = 6'd61;
  localparam logic [MODE_W-1:0] MODE_RESET = LE_CRLF;
  localparam int                MAX_WRAP_CAP = 61;

  localparam logic [CHAR_W-1:0] CH_SP  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

  // output queue
  localparam int OFIFO_AW    = 2;
  localparam int OFIFO_DEPTH = 4;
  localparam int OFIFO_LW    = 3;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } out_push_t;

endpackage

// ----- hdl/wws_if.sv -----
// request and result channel interfaces
interface wws_in_if import wws_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [CHAR_W-1:0] in_char;

  modport source(output valid, req_type, in_char, input ready);
  modport sink(input valid, req_type, in_char, output ready);
endinterface

interface wws_out_if import wws_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              last;

  modport source(output valid, out_char, last, input ready);
  modport sink(input valid, out_char, last, output ready);
endinterface

// ----- hdl/greedy_word_wrap_stream.sv -----
// greedy word wrap: line held in a ring memory, results sent through a short queue
// throughput: one result byte per cycle while the result queue has room, set by the
//   single read port of the line store; input is not ready until a request's bytes are issued
// reset: synchronous active-low rst_n clears counters, pointers and queue; the line store
//   keeps its contents and needs no clearing pass, since only written entries are read
module greedy_word_wrap_stream import wws_pkg::*; #(
  parameter int LINE_STORE_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  wws_in_if.sink                in_req,
  wws_out_if.source             out_res
);

  localparam int DEPTH = LINE_STORE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int CAP_N = (MAX_WRAP_CAP < DEPTH - 1) ? MAX_WRAP_CAP : DEPTH - 1;
  localparam logic [CW-1:0] CAP_C   = CW'(CAP_N);
  localparam logic [CW-1:0] LAST_C  = CW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  // ring index add, the sum stays below twice the depth
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a,
                                             input logic [AW-1:0] b,
                                             input logic          cin);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b} + {{AW{1'b0}}, cin};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  // configuration registers
  logic [WRAP_W-1:0] wrap_r;
  logic [MODE_W-1:0] mode_r;

  // line state: ring head, held count, last break position
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] bp_r, bp_nxt;
  logic          bv_r, bv_nxt;

  // emission sequencer: store bytes from base, then up to two fixed bytes
  logic [AW-1:0]     base_r, base_nxt;
  logic [CW-1:0]     em_idx_r, em_idx_nxt;
  logic [CW-1:0]     em_len_r, em_len_nxt;
  logic [1:0]        tail_n_r, tail_n_nxt;
  logic [CHAR_W-1:0] tail0_r, tail0_nxt;
  logic [CHAR_W-1:0] tail1_r, tail1_nxt;

  // read stage: lines up fixed bytes with the memory read latency
  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_mem_r, s1_mem_nxt;
  logic              s1_last_r, s1_last_nxt;
  logic [CHAR_W-1:0] s1_char_r, s1_char_nxt;

  logic              busy, can_issue, acc;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [CHAR_W-1:0] mem_rdata;
  logic [OFIFO_LW-1:0] fifo_level;
  out_push_t         push;

  // request decode
  logic [CHAR_W-1:0] c;
  logic              is_eol, is_brk;
  logic [CW-1:0]     pos, count_inc, bp_eff, rest, eff_wrap;
  logic              bv_eff;
  logic [WRAP_W-1:0] w_nz;

  assign busy      = (em_idx_r < em_len_r) || (tail_n_r != 2'd0);
  assign can_issue = ({1'b0, fifo_level} + {{OFIFO_LW{1'b0}}, s1_valid_r})
                     < (OFIFO_LW+1)'(OFIFO_DEPTH);
  assign in_req.ready = !busy;
  assign acc = in_req.valid && in_req.ready;

  // config port; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_r <= WRAP_RESET;
      mode_r <= MODE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WRAP_LENGTH:   wrap_r <= cfg_wdata[WRAP_W-1:0];
        REG_LINE_END_MODE: mode_r <= cfg_wdata[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    c      = in_req.in_char;
    is_eol = (c == CH_CR) || (c == CH_LF);
    is_brk = (c == CH_SP) || (c == CH_TAB);
    // store never overflows, position clamped anyway
    pos       = (count_r >= DEPTH_C) ? LAST_C : count_r;
    count_inc = pos + CW'(1);
    bp_eff    = is_brk ? pos : bp_r;
    bv_eff    = is_brk || bv_r;
    rest      = count_inc - bp_eff - CW'(1);
    // zero acts as one, too large acts as the cap
    w_nz = (wrap_r == '0) ? WRAP_W'(1) : wrap_r;
    if ({1'b0, w_nz} > 7'(CAP_N)) begin
      eff_wrap = CAP_C;
    end else begin
      eff_wrap = CW'(w_nz);
    end
  end

  always_comb begin
    head_nxt     = head_r;
    count_nxt    = count_r;
    bp_nxt       = bp_r;
    bv_nxt       = bv_r;
    base_nxt     = base_r;
    em_idx_nxt   = em_idx_r;
    em_len_nxt   = em_len_r;
    tail_n_nxt   = tail_n_r;
    tail0_nxt    = tail0_r;
    tail1_nxt    = tail1_r;
    s1_valid_nxt = 1'b0;
    s1_mem_nxt   = 1'b0;
    s1_last_nxt  = 1'b0;
    s1_char_nxt  = tail0_r;
    mem_we       = 1'b0;
    mem_waddr    = ring_add(head_r, pos[AW-1:0], 1'b0);
    mem_re       = 1'b0;
    mem_raddr    = ring_add(base_r, em_idx_r[AW-1:0], 1'b0);

    if (acc) begin
      base_nxt   = head_r;
      em_idx_nxt = '0;
      em_len_nxt = '0;
      tail_n_nxt = 2'd0;
      if (in_req.req_type == REQ_FLUSH) begin
        // flush: send what is held, nothing if empty
        em_len_nxt = count_r;
        count_nxt  = '0;
        bv_nxt     = 1'b0;
      end else if (is_eol) begin
        // hard line end: held line then the CR or LF itself
        em_len_nxt = count_r;
        tail_n_nxt = 2'd1;
        tail0_nxt  = c;
        count_nxt  = '0;
        bv_nxt     = 1'b0;
      end else begin
        mem_we = 1'b1;
        if (count_inc > eff_wrap) begin
          case (mode_r)
            LE_CR: begin
              tail_n_nxt = 2'd1;
              tail0_nxt  = CH_CR;
            end
            LE_LF: begin
              tail_n_nxt = 2'd1;
              tail0_nxt  = CH_LF;
            end
            default: begin
              tail_n_nxt = 2'd2;
              tail0_nxt  = CH_CR;
              tail1_nxt  = CH_LF;
            end
          endcase
          bv_nxt = 1'b0;
          if (bv_eff) begin
            // cut at the break, drop it, keep the rest by moving the head
            em_len_nxt = bp_eff;
            count_nxt  = rest;
            head_nxt   = ring_add(head_r, bp_eff[AW-1:0], 1'b1);
          end else begin
            // no break: whole line goes out
            em_len_nxt = count_inc;
            count_nxt  = '0;
          end
        end else begin
          count_nxt = count_inc;
          bp_nxt    = bp_eff;
          bv_nxt    = bv_eff;
        end
      end
    end else if (busy && can_issue) begin
      s1_valid_nxt = 1'b1;
      if (em_idx_r < em_len_r) begin
        mem_re      = 1'b1;
        s1_mem_nxt  = 1'b1;
        s1_last_nxt = ((em_idx_r + CW'(1)) == em_len_r) && (tail_n_r == 2'd0);
        em_idx_nxt  = em_idx_r + CW'(1);
      end else begin
        s1_char_nxt = tail0_r;
        s1_last_nxt = (tail_n_r == 2'd1);
        tail0_nxt   = tail1_r;
        tail_n_nxt  = tail_n_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      count_r    <= '0;
      bv_r       <= 1'b0;
      em_idx_r   <= '0;
      em_len_r   <= '0;
      tail_n_r   <= 2'd0;
      s1_valid_r <= 1'b0;
    end else begin
      head_r     <= head_nxt;
      count_r    <= count_nxt;
      bv_r       <= bv_nxt;
      em_idx_r   <= em_idx_nxt;
      em_len_r   <= em_len_nxt;
      tail_n_r   <= tail_n_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
    // payload, meaningful only under the control state above
    bp_r      <= bp_nxt;
    base_r    <= base_nxt;
    tail0_r   <= tail0_nxt;
    tail1_r   <= tail1_nxt;
    s1_mem_r  <= s1_mem_nxt;
    s1_last_r <= s1_last_nxt;
    s1_char_r <= s1_char_nxt;
  end

  wws_line_store #(.DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (c),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // memory bytes join fixed bytes in order at the queue
  always_comb begin
    push.valid     = s1_valid_r;
    push.item.ch   = s1_mem_r ? mem_rdata : s1_char_r;
    push.item.last = s1_last_r;
  end

  wws_out_fifo u_ofifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .level   (fifo_level),
    .out_res (out_res)
  );

  // a byte in the read stage always has a free queue slot
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (fifo_level < OFIFO_LW'(OFIFO_DEPTH)))
    else $error("result queue overflow");

  // the byte marked last closes the run, nothing is left to send
  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_last_r) |-> !busy)
    else $error("last byte issued with work pending");

  // flush of an empty line makes no results
  a_empty_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_req.req_type == REQ_FLUSH) && (count_r == '0)) |=> !busy)
    else $error("empty flush started a run");

  // held count stays within the store
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> (count_r < DEPTH_C))
    else $error("line count beyond store depth");

endmodule

// ----- hdl/wws_line_store.sv -----
// line store memory, one write port and one registered read port
module wws_line_store import wws_pkg::*; #(
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [CHAR_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [CHAR_W-1:0] rdata
);

  logic [CHAR_W-1:0] mem [DEPTH];
  logic [CHAR_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/wws_out_fifo.sv -----
// small result queue that drives the output channel
module wws_out_fifo import wws_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  out_push_t           push,
  output logic [OFIFO_LW-1:0] level,
  wws_out_if.source           out_res
);

  out_item_t             q [OFIFO_DEPTH];
  logic [OFIFO_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [OFIFO_LW-1:0]   cnt_r;
  logic                  pop;

  assign pop = out_res.valid && out_res.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr_r <= wr_ptr_r + OFIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + OFIFO_AW'(1);
      end
      cnt_r <= cnt_r + OFIFO_LW'(push.valid) - OFIFO_LW'(pop);
    end
    if (push.valid) begin
      q[wr_ptr_r] <= push.item;
    end
  end

  assign level            = cnt_r;
  assign out_res.valid    = (cnt_r != '0);
  assign out_res.out_char = q[rd_ptr_r].ch;
  assign out_res.last     = q[rd_ptr_r].last;

endmodule

// ----- verif/greedy_word_wrap_stream_tb.sv -----
// testbench for the greedy word wrap stream block: directed and random text against a predictor
`timescale 1ns / 100ps

module greedy_word_wrap_stream_tb;
  import wws_pkg::*;

  localparam int CLK_PERIOD    = 12;
  localparam int RESET_CYCLES  = 12;
  localparam int LINE_DEPTH    = 64;
  // idle cycles waited after the last result drains, before the registers are touched
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SEGMENT_ITEMS = 48;

  // mode code 3 is not named in the package; the block treats it as cr lf
  localparam logic [MODE_W-1:0] LE_ALIAS = 2'd3;

  logic clk = 1'b0;
  logic rst_n;

  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  wws_in_if  in_req_if ();
  wws_out_if out_res_if ();

  greedy_word_wrap_stream dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_req    (in_req_if),
    .out_res   (out_res_if)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor state: the held line, its last break position and the registers
  // ---------------------------------------------------------------------------
  logic [CHAR_W-1:0] line_buf [LINE_DEPTH];
  int unsigned       line_len;
  int unsigned       brk_pos;
  bit                brk_valid;
  logic [WRAP_W-1:0] wrap_reg;
  logic [MODE_W-1:0] mode_reg;

  logic [CHAR_W-1:0] run_bytes [$];   // bytes one request produces, built up by the predictor
  out_item_t         expected_bytes [$];

  // idling knobs for the current phase, in percent
  int send_idle_pct;
  int stall_pct;

  // both start at zero and each has a single writer
  int fail_count;
  int cycle_count;

  // copy the first n held bytes to the current run
  task automatic emit_held_bytes(input int unsigned n);
    for (int unsigned i = 0; i < n && i < LINE_DEPTH; i++) run_bytes.push_back(line_buf[i]);
  endtask

  // inserted line end, per the mode register
  task automatic emit_line_end();
    case (mode_reg)
      LE_CR: run_bytes.push_back(CH_CR);
      LE_LF: run_bytes.push_back(CH_LF);
      default: begin
        // cr lf, and the unnamed code 3 as well
        run_bytes.push_back(CH_CR);
        run_bytes.push_back(CH_LF);
      end
    endcase
  endtask

  // work out the result bytes of one accepted request and queue them
  task automatic predict_wrap(input logic rtype, input logic [CHAR_W-1:0] ch);
    int unsigned pos;
    int unsigned cut;
    int unsigned rest;
    int unsigned limit_len;
    int unsigned cap;
    out_item_t   item;

    run_bytes.delete();
    if (rtype == REQ_FLUSH) begin
      // flush: in_char ignored, empty store gives nothing
      emit_held_bytes(line_len);
      line_len  = 0;
      brk_valid = 1'b0;
    end else if (ch == CH_CR || ch == CH_LF) begin
      // hard line end: held line plus the byte itself
      emit_held_bytes(line_len);
      run_bytes.push_back(ch);
      line_len  = 0;
      brk_valid = 1'b0;
    end else begin
      pos = line_len;
      if (pos >= LINE_DEPTH) pos = LINE_DEPTH - 1;
      line_buf[pos] = ch;
      line_len      = pos + 1;
      if (ch == CH_SP || ch == CH_TAB) begin
        brk_pos   = pos;
        brk_valid = 1'b1;
      end
      // zero acts as one, anything past the cap acts as the cap
      cap       = (MAX_WRAP_CAP < LINE_DEPTH - 1) ? MAX_WRAP_CAP : LINE_DEPTH - 1;
      limit_len = (wrap_reg == 0) ? 1 : wrap_reg;
      if (limit_len > cap) limit_len = cap;
      if (line_len > limit_len) begin
        if (brk_valid) begin
          // cut at the last blank, drop it, keep what follows
          cut  = brk_pos;
          rest = line_len - cut - 1;
          emit_held_bytes(cut);
          emit_line_end();
          for (int unsigned i = 0; i < rest; i++) line_buf[i] = line_buf[cut + 1 + i];
          line_len = rest;
        end else begin
          // no blank in the line: send all of it
          emit_held_bytes(line_len);
          emit_line_end();
          line_len = 0;
        end
        brk_valid = 1'b0;
      end
    end

    foreach (run_bytes[i]) begin
      item.ch   = run_bytes[i];
      item.last = (i == run_bytes.size() - 1);
      expected_bytes.push_back(item);
    end
  endtask

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // one request; returns at the edge that takes it, leaving valid high
  task automatic send_request(input logic rtype, input logic [CHAR_W-1:0] ch);
    // sender idles one cycle at a time with the phase's chance
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_req_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_req_if.valid    <= 1'b1;
    in_req_if.req_type <= rtype;
    in_req_if.in_char  <= ch;
    do @(posedge clk); while (!in_req_if.ready);
    predict_wrap(rtype, ch);
  endtask

  task automatic send_word(input string s);
    foreach (s[i]) send_request(REQ_TEXT, s[i]);
  endtask

  // stop sending and let every queued byte drain, then give the block time to settle
  task automatic wait_for_idle();
    in_req_if.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both registers, written back to back while the block is quiet
  task automatic set_config(input logic [WRAP_W-1:0] wrap_val, input logic [MODE_W-1:0] mode_val);
    wait_for_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_WRAP_LENGTH;
    cfg_wdata <= CFG_DATA_W'(wrap_val);
    @(posedge clk);
    wrap_reg = wrap_val;
    cfg_index <= REG_LINE_END_MODE;
    cfg_wdata <= CFG_DATA_W'(mode_val);
    @(posedge clk);
    mode_reg = mode_val;
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // test tasks
  // ---------------------------------------------------------------------------

  // flush with nothing held: no bytes, in_char ignored
  task automatic test_flush_empty();
    send_request(REQ_FLUSH, 8'hFF);
  endtask

  // wrap length zero acts as one, cr line end, hard line ends, flush with a held byte
  task automatic test_min_wrap_cr();
    set_config(6'd0, LE_CR);
    send_word("ab");                 // no blank: whole line then cr
    send_request(REQ_TEXT, CH_SP);
    send_word("x");                  // blank at the start: only the line end, keep x
    send_request(REQ_TEXT, CH_CR);   // held x then the cr itself
    send_request(REQ_TEXT, CH_LF);   // empty line: just the lf
    send_word("q");
    send_request(REQ_FLUSH, CH_LF);  // flush ignores its byte
  endtask

  // tab as break, mode code 3 gives cr lf, byte extremes without a break
  task automatic test_tab_break_alias_mode();
    set_config(6'd3, LE_ALIAS);
    send_word("a");
    send_request(REQ_TEXT, CH_TAB);
    send_word("bc");                 // wraps at the tab, keeps bc
    send_request(REQ_TEXT, 8'h00);
    send_request(REQ_TEXT, 8'hFF);   // no break left: whole line out
    send_request(REQ_FLUSH, 8'h00);  // store empty again
  endtask

  // oversized wrap length clamps; lowering it mid-line wraps on the next byte
  task automatic test_wide_wrap_lowered();
    set_config(6'd63, LE_LF);
    send_word("ab cdef");
    set_config(6'd2, LE_LF);
    send_word("g");                  // cuts at the blank, remainder still longer than 2
    send_request(REQ_FLUSH, 8'h55);
  endtask

  // word-like random text under random settings, two register settings per phase
  task automatic test_random_traffic(input int idle_pct, input int stall_chance);
    logic [WRAP_W-1:0] wrap_val;
    logic [MODE_W-1:0] mode_val;
    int                sel;
    int                eol_pct;
    int                flush_pct;

    send_idle_pct = idle_pct;
    stall_pct     = stall_chance;
    for (int seg = 0; seg < 2; seg++) begin
      // extremes now and then, otherwise short lines so wraps are frequent
      case ($urandom_range(0, 9))
        0:       wrap_val = 6'd0;
        1:       wrap_val = 6'd1;
        2:       wrap_val = 6'd61;
        3:       wrap_val = 6'd63;
        default: wrap_val = WRAP_W'($urandom_range(2, 16));
      endcase
      mode_val = MODE_W'($urandom_range(0, 3));
      set_config(wrap_val, mode_val);

      // long lines only wrap if line ends and flushes are rare
      eol_pct   = (wrap_val >= 30) ? 0 : 6;
      flush_pct = (wrap_val >= 30) ? 1 : 3;
      repeat (SEGMENT_ITEMS) begin
        sel = $urandom_range(0, 99);
        if (sel < flush_pct)
          send_request(REQ_FLUSH, CHAR_W'($urandom_range(0, 255)));
        else if (sel < flush_pct + eol_pct)
          send_request(REQ_TEXT, $urandom_range(0, 1) ? CH_CR : CH_LF);
        else if (sel < flush_pct + eol_pct + 16)
          send_request(REQ_TEXT, CH_SP);
        else if (sel < flush_pct + eol_pct + 20)
          send_request(REQ_TEXT, CH_TAB);
        else if (sel < flush_pct + eol_pct + 28)
          // noise: any byte at all
          send_request(REQ_TEXT, CHAR_W'($urandom_range(0, 255)));
        else
          send_request(REQ_TEXT, CHAR_W'(8'h61 + $urandom_range(0, 25)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls and the in-order compare
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst_n) begin
      out_res_if.ready <= 1'b0;
    end else begin
      if (out_res_if.valid && out_res_if.ready) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected result: out_char %h last %b", out_res_if.out_char, out_res_if.last);
          fail_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_res_if.out_char !== want.ch) begin
            $error("out_char: expected %h, got %h", want.ch, out_res_if.out_char);
            fail_count++;
          end
          if (out_res_if.last !== want.last) begin
            $error("last: expected %b, got %b", want.last, out_res_if.last);
            fail_count++;
          end
        end
      end
      out_res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence of tests
  // ---------------------------------------------------------------------------
  initial begin
    // request side and register port known from time zero
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_WRAP_LENGTH;
    cfg_wdata          <= '0;
    in_req_if.valid    <= 1'b0;
    in_req_if.req_type <= REQ_TEXT;
    in_req_if.in_char  <= '0;

    // predictor mirrors the reset state; store contents are never read before written
    line_len      = 0;
    brk_pos       = 0;
    brk_valid     = 1'b0;
    wrap_reg      = WRAP_RESET;
    mode_reg      = MODE_RESET;
    send_idle_pct = 0;
    stall_pct     = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed part runs with no idling on either side
    test_flush_empty();
    test_min_wrap_cr();
    test_tab_break_alias_mode();
    test_wide_wrap_lowered();

    // random phases: none, sender idle, receiver stalling, both
    test_random_traffic(0, 0);
    test_random_traffic(61, 0);
    test_random_traffic(0, 61);
    test_random_traffic(24, 24);

    wait_for_idle();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
